### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/sdfb_pkg.sv
// ----------------------------------------------------------------------------
// Segment display frame builder package
// Shared types, constants and glyph tables.
// ----------------------------------------------------------------------------
`default_nettype none

package sdfb_pkg;

   localparam int FRAME_BYTES = 7;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [5:0] SEG_COUNT    = 6'd56;
   localparam logic [3:0] GLYPH_ZERO   = 4'd0;
   localparam logic [3:0] GLYPH_BLANK  = 4'd10;
   localparam logic [3:0] GLYPH_DEGREE = 4'd11;

   localparam logic [7:0] SIGN_BAR   = 8'b0011_0000;
   localparam logic [7:0] MINUS_MARK = 8'b0000_0100;
   localparam logic [7:0] PLUS_MARK  = 8'b0000_1110;
   localparam logic [7:0] POINT_MARK = 8'b1000_0000;
   localparam logic [7:0] COLON_MARK = 8'b0100_0000;
   localparam logic [7:0] ALL_ON     = 8'hFF;

   typedef enum logic [2:0] {
      OP_DIGITS  = 3'd0,
      OP_TIME    = 3'd1,
      OP_DATE    = 3'd2,
      OP_WEEKDAY = 3'd3,
      OP_TEMP    = 3'd4,
      OP_SEGTEST = 3'd5
   } op_type;

   // Byte k of the frame sits at bits [8k+7:8k].
   typedef logic [FRAME_BITS-1:0] frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] glyph_mask(input logic [3:0] g);
      logic [15:0] m;
      case (g)
         4'd0:    m = 16'h0FFF;
         4'd1:    m = 16'h07C0;
         4'd2:    m = 16'h1F7D;
         4'd3:    m = 16'h1FF5;
         4'd4:    m = 16'h17C7;
         4'd5:    m = 16'h1DF7;
         4'd6:    m = 16'h1DFF;
         4'd7:    m = 16'h0FC1;
         4'd8:    m = 16'h1FFF;
         4'd9:    m = 16'h1FF7;
         4'd11:   m = 16'h1A02;
         4'd12:   m = 16'h0C6E;
         default: m = 16'h0000;
      endcase
      return m;
   endfunction

   function automatic logic [15:0] day_left_mask(input logic [2:0] d);
      logic [15:0] m;
      case (d)
         3'd1:    m = 16'h0FDF;
         3'd2:    m = 16'h1ABF;
         3'd3:    m = 16'h0C6E;
         3'd4:    m = 16'h17C7;
         3'd5:    m = 16'h0FDF;
         3'd6:    m = 16'h0C6E;
         3'd7:    m = 16'h1ABF;
         default: m = 16'h0000;
      endcase
      return m;
   endfunction

   function automatic logic [15:0] day_right_mask(input logic [2:0] d);
      logic [15:0] m;
      case (d)
         3'd1:    m = 16'h17DF;
         3'd2:    m = 16'h2C01;
         3'd3:    m = 16'h1A1F;
         3'd4:    m = 16'h2C01;
         3'd5:    m = 16'h2C01;
         3'd6:    m = 16'h1CBF;
         3'd7:    m = 16'h0C6E;
         default: m = 16'h0000;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

### src/sdfb_front.sv
// ----------------------------------------------------------------------------
// Frame builder front end
// Classifies a request and composes its 56-bit frame from the glyph tables.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfb_front
   import sdfb_pkg::*;
(
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [2:0]       req_op,
   input  wire logic [3:0]       req_glyph_first,
   input  wire logic [3:0]       req_glyph_second,
   input  wire logic [3:0]       req_glyph_third,
   input  wire logic [3:0]       req_glyph_fourth,
   input  wire logic [2:0]       req_weekday,
   input  wire logic             req_negative,
   input  wire logic [3:0]       req_temp_tens,
   input  wire logic [3:0]       req_temp_units,
   input  wire logic [5:0]       req_segment_number,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output frame_type             q_frame
);

   logic [15:0] m1, m2, m3, m4;
   logic [7:0]  w [FRAME_BYTES];
   logic [7:0]  extra0, extra5, extra6;
   logic [5:0]  seg_idx;
   logic        has_frame;
   logic        seg_test;
   op_type      op;

   assign op = op_type'(req_op);

   always_comb begin
      m1 = '0;
      m2 = '0;
      m3 = '0;
      m4 = '0;
      extra0 = '0;
      extra5 = '0;
      extra6 = '0;
      has_frame = 1'b1;
      seg_test = 1'b0;
      case (op)
         OP_DIGITS, OP_TIME, OP_DATE: begin
            m1 = glyph_mask(req_glyph_first);
            m2 = glyph_mask(req_glyph_second);
            m3 = glyph_mask(req_glyph_third);
            m4 = glyph_mask(req_glyph_fourth);
            if (op == OP_TIME) begin
               extra0 = COLON_MARK;
            end
            if (op == OP_DATE) begin
               extra0 = POINT_MARK;
            end
         end
         OP_WEEKDAY: begin
            m2 = day_left_mask(req_weekday);
            m3 = day_right_mask(req_weekday);
         end
         OP_TEMP: begin
            if (req_temp_tens == '0 && req_temp_units == '0) begin
               m2 = glyph_mask(GLYPH_ZERO);
               m3 = glyph_mask(GLYPH_DEGREE);
            end else begin
               m2 = glyph_mask((req_temp_tens == '0) ? GLYPH_BLANK : req_temp_tens);
               m3 = glyph_mask(req_temp_units);
               m4 = glyph_mask(GLYPH_DEGREE);
               extra5 = SIGN_BAR;
               extra6 = req_negative ? MINUS_MARK : PLUS_MARK;
            end
         end
         OP_SEGTEST: begin
            seg_test = 1'b1;
            has_frame = (req_segment_number <= SEG_COUNT);
         end
         default: begin
            has_frame = 1'b0;
         end
      endcase
   end

   assign seg_idx = req_segment_number - 6'd1;

   // Place the four masks into the frame bytes; segment test overrides.
   always_comb begin
      w[0] = extra0 | m4[14:7];
      w[1] = {5'b0, m3[15:13]} | {m4[6:0], 1'b0};
      w[2] = m3[12:5];
      w[3] = {2'b0, m2[15:10]} | {m3[4:0], 3'b0};
      w[4] = m2[9:2];
      w[5] = extra5 | m1[15:8] | {m2[1:0], 6'b0};
      w[6] = extra6 | m1[7:0];
      if (seg_test) begin
         for (int b = 0; b < FRAME_BYTES; b++) begin
            if (req_segment_number == '0) begin
               w[b] = ALL_ON;
            end else if (3'(FRAME_BYTES - 1 - b) == seg_idx[5:3]) begin
               w[b] = 8'd1 << seg_idx[2:0];
            end else begin
               w[b] = '0;
            end
         end
      end
   end

   always_comb begin
      for (int b = 0; b < FRAME_BYTES; b++) begin
         q_frame[b*8 +: 8] = w[b];
      end
   end

   assign req_full = q_status.full;
   assign q_push   = req_push && !q_status.full && has_frame;

endmodule

`default_nettype wire

### src/sdfb_queue.sv
// ----------------------------------------------------------------------------
// Frame queue
// Short first-in first-out buffer of composed frames.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfb_queue
   import sdfb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire frame_type  push_frame,
   input  wire logic       pop,
   output frame_type       pop_frame,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_frame = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

`default_nettype wire

### src/sdfb_back.sv
// ----------------------------------------------------------------------------
// Frame serializer back end
// Loads a frame from the queue and hands it out one byte per pop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sdfb_back
   import sdfb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire frame_type        q_frame,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_shift_reset,
   output logic                  rsp_last
);

   localparam logic [2:0] LAST_BYTE = 3'(FRAME_BYTES - 1);

   frame_type  frame_ff, frame_in;
   logic [2:0] byte_cnt_ff, byte_cnt_in;
   logic       busy_ff, busy_in;
   logic       take, load;

   assign take = rsp_pop && busy_ff;
   assign load = !q_status.empty && (!busy_ff || (take && byte_cnt_ff == LAST_BYTE));
   assign q_pop = load;

   always_comb begin
      frame_in    = frame_ff;
      byte_cnt_in = byte_cnt_ff;
      busy_in     = busy_ff;
      if (take) begin
         if (byte_cnt_ff == LAST_BYTE) begin
            busy_in     = 1'b0;
            byte_cnt_in = '0;
         end else begin
            frame_in    = frame_ff >> 8;
            byte_cnt_in = byte_cnt_ff + 1'b1;
         end
      end
      if (load) begin
         frame_in    = q_frame;
         byte_cnt_in = '0;
         busy_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         byte_cnt_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign rsp_empty       = !busy_ff;
   assign rsp_frame_byte  = frame_ff[7:0];
   assign rsp_shift_reset = (byte_cnt_ff == '0);
   assign rsp_last        = (byte_cnt_ff == LAST_BYTE);

   `ASSERT_IMPLY(a_idle_count_zero, clock, reset, !busy_ff, byte_cnt_ff == '0)
   `ASSERT_NEXT(a_frame_continues, clock, reset, take && !rsp_last, busy_ff && byte_cnt_ff != '0)
   `ASSERT_IMPLY(a_load_only_when_free, clock, reset, q_pop, !busy_ff || (take && rsp_last))

endmodule

`default_nettype wire

### src/segment_display_frame_builder.sv
// Path: an accepted request's frame is written into the queue, then loaded
// into the back end when it is free, which shows its first byte on the ports.
// Throughput: one byte per pop, set by the byte serializer; the front end
// takes a request every cycle while the two-frame queue has room. Requests
// that produce no frame are taken and dropped.
// Reset: synchronous; empties the queue and leaves the serializer idle.
// ----------------------------------------------------------------------------
// Segment display frame builder
// Builds 56-bit indicator frames and emits them as seven bytes each.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_display_frame_builder
   import sdfb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [2:0] req_op,
   input  wire logic [3:0] req_glyph_first,
   input  wire logic [3:0] req_glyph_second,
   input  wire logic [3:0] req_glyph_third,
   input  wire logic [3:0] req_glyph_fourth,
   input  wire logic [2:0] req_weekday,
   input  wire logic       req_negative,
   input  wire logic [3:0] req_temp_tens,
   input  wire logic [3:0] req_temp_units,
   input  wire logic [5:0] req_segment_number,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_frame_byte,
   output logic            rsp_shift_reset,
   output logic            rsp_last
);

   // The front end composes a whole frame combinationally from the request
   // and writes it straight into the queue.
   queue_status_type q_status;
   frame_type        push_frame;
   frame_type        pop_frame;
   logic             q_push;
   logic             q_pop;

   sdfb_front u_front (
      .req_push           (req_push),
      .req_full           (req_full),
      .req_op             (req_op),
      .req_glyph_first    (req_glyph_first),
      .req_glyph_second   (req_glyph_second),
      .req_glyph_third    (req_glyph_third),
      .req_glyph_fourth   (req_glyph_fourth),
      .req_weekday        (req_weekday),
      .req_negative       (req_negative),
      .req_temp_tens      (req_temp_tens),
      .req_temp_units     (req_temp_units),
      .req_segment_number (req_segment_number),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_frame            (push_frame)
   );

   // The queue lets the front keep taking requests while the back end is
   // still shifting out an earlier frame.
   sdfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (push_frame),
      .pop        (q_pop),
      .pop_frame  (pop_frame),
      .status     (q_status)
   );

   // The back end holds the current frame in a shift register and loads the
   // next one in the same cycle that the final byte is popped, so frames
   // follow each other without a gap.
   sdfb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_frame         (pop_frame),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_shift_reset (rsp_shift_reset),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

### bench/tb_segment_display_frame_builder.sv
// ----------------------------------------------------------------------------
// Segment display frame builder testbench
// Feeds display requests through the push/full side, predicts the seven
// frame bytes each request should produce, and checks every byte popped
// from the result side in order, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_display_frame_builder;
   import sdfb_pkg::*;

   // Opcodes that the block does not know. Requests carrying them are taken
   // and dropped without producing any frame bytes.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // Glyph tables, entry 0 in the lowest slice. Glyph codes at or past
   // GLYPH_COUNT fall off the end of the table and show as blank.
   localparam int GLYPH_COUNT = 13;
   localparam logic [12:0][15:0] GLYPH_SET = {
      16'h0C6E, 16'h1A02, 16'h0000, 16'h1FF7, 16'h1FFF, 16'h0FC1, 16'h1DFF,
      16'h1DF7, 16'h17C7, 16'h1FF5, 16'h1F7D, 16'h07C0, 16'h0FFF
   };
   localparam logic [7:0][15:0] DAY_LEFT_SET = {
      16'h1ABF, 16'h0C6E, 16'h0FDF, 16'h17C7,
      16'h0C6E, 16'h1ABF, 16'h0FDF, 16'h0000
   };
   localparam logic [7:0][15:0] DAY_RIGHT_SET = {
      16'h0C6E, 16'h1CBF, 16'h2C01, 16'h2C01,
      16'h1A1F, 16'h2C01, 16'h17DF, 16'h0000
   };

   localparam int RANDOM_REQUESTS = 158;
   localparam int CALM_TAIL_SIZE  = 25;
   localparam int MAX_IDLE_BURST  = 18;
   localparam int SETTLE_CYCLES   = 20;
   localparam int STALL_LIMIT     = 2000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] glyph_first;
      logic [3:0] glyph_second;
      logic [3:0] glyph_third;
      logic [3:0] glyph_fourth;
      logic [2:0] weekday;
      logic       negative;
      logic [3:0] temp_tens;
      logic [3:0] temp_units;
      logic [5:0] segment_number;
      logic       drain_first;   // wait for all outstanding bytes before sending
   } display_request_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       shift_reset;
      logic       last;
   } frame_byte_type;

   // Byte k of a frame is slice k.
   typedef logic [FRAME_BYTES-1:0][7:0] indicator_frame_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [2:0] req_op = '0;
   logic [3:0] req_glyph_first = '0;
   logic [3:0] req_glyph_second = '0;
   logic [3:0] req_glyph_third = '0;
   logic [3:0] req_glyph_fourth = '0;
   logic [2:0] req_weekday = '0;
   logic       req_negative = 1'b0;
   logic [3:0] req_temp_tens = '0;
   logic [3:0] req_temp_units = '0;
   logic [5:0] req_segment_number = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic       rsp_shift_reset;
   logic       rsp_last;

   display_request_type request_backlog[$];
   frame_byte_type      frame_bytes_due[$];

   logic drain_next = 1'b0;
   logic calm_tail = 1'b0;
   int   push_gap = 0;
   int   pop_gap = 0;
   int   mismatch_count = 0;
   int   stall_cycles = 0;

   segment_display_frame_builder dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_op             (req_op),
      .req_glyph_first    (req_glyph_first),
      .req_glyph_second   (req_glyph_second),
      .req_glyph_third    (req_glyph_third),
      .req_glyph_fourth   (req_glyph_fourth),
      .req_weekday        (req_weekday),
      .req_negative       (req_negative),
      .req_temp_tens      (req_temp_tens),
      .req_temp_units     (req_temp_units),
      .req_segment_number (req_segment_number),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_shift_reset    (rsp_shift_reset),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Frame prediction
   // ------------------------------------------------------------------------

   function automatic logic [15:0] glyph_lookup(input logic [3:0] g);
      return (g < GLYPH_COUNT) ? GLYPH_SET[g] : 16'h0000;
   endfunction

   // ORs a 16-bit segment mask into the frame at one of the four indicator
   // positions. Each position straddles byte boundaries differently.
   function automatic indicator_frame_type place_mask(input indicator_frame_type f,
                                                      input int position,
                                                      input logic [15:0] m);
      case (position)
         1: begin
            f[5] |= m[15:8];
            f[6] |= m[7:0];
         end
         2: begin
            f[3] |= {2'b00, m[15:10]};
            f[4] |= m[9:2];
            f[5] |= {m[1:0], 6'b000000};
         end
         3: begin
            f[1] |= {5'b00000, m[15:13]};
            f[2] |= m[12:5];
            f[3] |= {m[4:0], 3'b000};
         end
         default: begin
            f[0] |= m[14:7];
            f[1] |= {m[6:0], 1'b0};
         end
      endcase
      return f;
   endfunction

   // Builds the frame a request should produce. Returns 0 when the request
   // is one the block drops without output.
   function automatic logic frame_for_request(input display_request_type r,
                                              output indicator_frame_type f);
      logic [3:0] tens;
      int         idx;
      logic       made;
      f = '0;
      made = 1'b1;
      tens = r.temp_tens;
      case (r.op)
         OP_DIGITS, OP_TIME, OP_DATE: begin
            f = place_mask(f, 1, glyph_lookup(r.glyph_first));
            f = place_mask(f, 2, glyph_lookup(r.glyph_second));
            if (r.op == OP_TIME) f[0] |= COLON_MARK;
            if (r.op == OP_DATE) f[0] |= POINT_MARK;
            f = place_mask(f, 3, glyph_lookup(r.glyph_third));
            f = place_mask(f, 4, glyph_lookup(r.glyph_fourth));
         end
         OP_WEEKDAY: begin
            f = place_mask(f, 2, DAY_LEFT_SET[r.weekday]);
            f = place_mask(f, 3, DAY_RIGHT_SET[r.weekday]);
         end
         OP_TEMP: begin
            if (r.temp_tens == 4'd0 && r.temp_units == 4'd0) begin
               // A plain zero shows without a sign, degree right after it.
               f = place_mask(f, 2, glyph_lookup(GLYPH_ZERO));
               f = place_mask(f, 3, glyph_lookup(GLYPH_DEGREE));
            end else begin
               if (tens == 4'd0) tens = GLYPH_BLANK;
               f[5] |= SIGN_BAR;
               f[6] |= r.negative ? MINUS_MARK : PLUS_MARK;
               f = place_mask(f, 2, glyph_lookup(tens));
               f = place_mask(f, 3, glyph_lookup(r.temp_units));
               f = place_mask(f, 4, glyph_lookup(GLYPH_DEGREE));
            end
         end
         OP_SEGTEST: begin
            if (r.segment_number > SEG_COUNT) begin
               made = 1'b0;
            end else if (r.segment_number == 6'd0) begin
               f = {FRAME_BYTES{ALL_ON}};
            end else begin
               idx = int'(r.segment_number) - 1;
               f[FRAME_BYTES - 1 - idx / 8] = 8'd1 << (idx % 8);
            end
         end
         default: begin
            made = 1'b0;
         end
      endcase
      return made;
   endfunction

   // ------------------------------------------------------------------------
   // Request construction. Fields that a request's op does not use are left
   // random so that every input bit toggles throughout the run.
   // ------------------------------------------------------------------------

   function automatic display_request_type scrambled_request();
      display_request_type r;
      r.op             = 3'($urandom);
      r.glyph_first    = 4'($urandom);
      r.glyph_second   = 4'($urandom);
      r.glyph_third    = 4'($urandom);
      r.glyph_fourth   = 4'($urandom);
      r.weekday        = 3'($urandom);
      r.negative       = 1'($urandom);
      r.temp_tens      = 4'($urandom);
      r.temp_units     = 4'($urandom);
      r.segment_number = 6'($urandom);
      r.drain_first    = 1'b0;
      return r;
   endfunction

   task automatic enqueue_request(input display_request_type r);
      r.drain_first = drain_next;
      drain_next = 1'b0;
      request_backlog.push_back(r);
   endtask

   task automatic queue_glyphs(input logic [2:0] op, input logic [3:0] a,
                               input logic [3:0] b, input logic [3:0] c,
                               input logic [3:0] d);
      display_request_type r;
      r = scrambled_request();
      r.op = op;
      r.glyph_first = a;
      r.glyph_second = b;
      r.glyph_third = c;
      r.glyph_fourth = d;
      enqueue_request(r);
   endtask

   task automatic queue_weekday(input logic [2:0] day);
      display_request_type r;
      r = scrambled_request();
      r.op = OP_WEEKDAY;
      r.weekday = day;
      enqueue_request(r);
   endtask

   task automatic queue_temperature(input logic neg, input logic [3:0] tens,
                                    input logic [3:0] units);
      display_request_type r;
      r = scrambled_request();
      r.op = OP_TEMP;
      r.negative = neg;
      r.temp_tens = tens;
      r.temp_units = units;
      enqueue_request(r);
   endtask

   task automatic queue_segment(input logic [2:0] op, input logic [5:0] seg);
      display_request_type r;
      r = scrambled_request();
      r.op = op;
      r.segment_number = seg;
      enqueue_request(r);
   endtask

   // Mostly valid glyphs, now and then a code past the table end.
   function automatic logic [3:0] pick_glyph();
      if ($urandom_range(0, 5) == 0) return 4'($urandom_range(GLYPH_COUNT, 15));
      return 4'($urandom_range(0, GLYPH_COUNT - 1));
   endfunction

   // Temperature digit: usually a decimal digit, occasionally any 4-bit code.
   function automatic logic [3:0] pick_temp_digit();
      if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, 9));
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. An accepted request is removed from the backlog and its
   // frame bytes are predicted on the spot. Between requests the driver may
   // go quiet for a random burst, except in the calm tail of the run. A
   // request marked drain_first is held back until every byte already
   // predicted has been popped.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      display_request_type taken;
      display_request_type upcoming;
      indicator_frame_type frame;
      frame_byte_type      due;
      logic                sent;
      logic                next_push;
      if (!reset) begin
         sent = req_push && !req_full;
         if (sent) begin
            taken = request_backlog.pop_front();
            if (frame_for_request(taken, frame)) begin
               for (int k = 0; k < FRAME_BYTES; k++) begin
                  due.frame_byte  = frame[k];
                  due.shift_reset = (k == 0);
                  due.last        = (k == FRAME_BYTES - 1);
                  frame_bytes_due.push_back(due);
               end
            end
         end

         if (req_push && !sent) begin
            // The block is full; the same request stays on the ports.
            next_push = 1'b1;
         end else if (push_gap > 0) begin
            push_gap = push_gap - 1;
            next_push = 1'b0;
         end else if (request_backlog.size() == 0) begin
            next_push = 1'b0;
         end else if (request_backlog[0].drain_first &&
                      frame_bytes_due.size() != 0) begin
            next_push = 1'b0;
         end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
            push_gap = $urandom_range(1, MAX_IDLE_BURST) - 1;
            next_push = 1'b0;
         end else begin
            upcoming = request_backlog[0];
            next_push = 1'b1;
            req_op             <= upcoming.op;
            req_glyph_first    <= upcoming.glyph_first;
            req_glyph_second   <= upcoming.glyph_second;
            req_glyph_third    <= upcoming.glyph_third;
            req_glyph_fourth   <= upcoming.glyph_fourth;
            req_weekday        <= upcoming.weekday;
            req_negative       <= upcoming.negative;
            req_temp_tens      <= upcoming.temp_tens;
            req_temp_units     <= upcoming.temp_units;
            req_segment_number <= upcoming.segment_number;
         end
         req_push  <= next_push;
         calm_tail <= (request_backlog.size() <= CALM_TAIL_SIZE);
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Each popped byte is compared with the oldest predicted
   // byte. A pop with nothing predicted is an error as well. The pop side
   // stalls in random bursts until the calm tail.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      frame_byte_type want;
      logic           next_pop;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (frame_bytes_due.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected frame byte %02h (shift_reset %0b last %0b)",
                           rsp_frame_byte, rsp_shift_reset, rsp_last);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== want.frame_byte ||
                   rsp_shift_reset !== want.shift_reset ||
                   rsp_last !== want.last) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"frame byte mismatch: expected %02h sr %0b last %0b,",
                               " got %02h sr %0b last %0b"},
                              want.frame_byte, want.shift_reset, want.last,
                              rsp_frame_byte, rsp_shift_reset, rsp_last);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end

         if (pop_gap > 0) begin
            pop_gap = pop_gap - 1;
            next_pop = 1'b0;
         end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
            pop_gap = $urandom_range(1, MAX_IDLE_BURST) - 1;
            next_pop = 1'b0;
         end else begin
            next_pop = 1'b1;
         end
         rsp_pop <= next_pop;
      end
   end

   // Cycles in a row in which neither side moved a request or a byte.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus and run control.
   // ------------------------------------------------------------------------
   initial begin : run_control
      int   counted;
      int   pick;
      logic neg;
      logic [3:0] tens;
      logic [3:0] units;

      // Directed part: every glyph code on one of the positions, all display modes,
      // glyph codes past the table end, the temperature special cases and
      // the segment test extremes, including out-of-range segments and the
      // two unknown opcodes that produce nothing.
      queue_glyphs(OP_DIGITS, 4'd0, 4'd1, 4'd2, 4'd3);
      queue_glyphs(OP_DIGITS, 4'd4, 4'd5, 4'd6, 4'd7);
      queue_glyphs(OP_DIGITS, 4'd8, 4'd9, 4'd10, 4'd11);
      queue_glyphs(OP_DIGITS, 4'd12, 4'd13, 4'd14, 4'd15);
      queue_glyphs(OP_TIME, 4'd1, 4'd2, 4'd3, 4'd4);
      queue_glyphs(OP_DATE, 4'd3, 4'd1, 4'd1, 4'd2);
      queue_weekday(3'd0);
      queue_weekday(3'd1);
      queue_weekday(3'd2);
      queue_weekday(3'd7);
      // Let the block drain completely before the temperature cases.
      drain_next = 1'b1;
      queue_temperature(1'b0, 4'd0, 4'd0);
      queue_temperature(1'b1, 4'd0, 4'd5);
      queue_temperature(1'b1, 4'd9, 4'd9);
      queue_temperature(1'b0, 4'd1, 4'd0);
      queue_temperature(1'b0, 4'd15, 4'd14);
      queue_segment(OP_SEGTEST, 6'd0);
      queue_segment(OP_SEGTEST, 6'd1);
      queue_segment(OP_SEGTEST, SEG_COUNT);
      queue_segment(OP_SEGTEST, SEG_COUNT + 6'd1);
      queue_segment(OP_SEGTEST, 6'd63);
      queue_segment(OP_SPARE_A, 6'($urandom));
      queue_segment(OP_SPARE_B, 6'($urandom));

      // Random part. Dropped requests count toward the total as well.
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick < 7) begin
            queue_glyphs(3'($urandom_range(OP_DIGITS, OP_DATE)), pick_glyph(),
                         pick_glyph(), pick_glyph(), pick_glyph());
         end else if (pick < 10) begin
            queue_weekday(3'($urandom_range(0, 7)));
         end else if (pick < 15) begin
            neg = 1'($urandom);
            tens = pick_temp_digit();
            units = pick_temp_digit();
            if ($urandom_range(0, 7) == 0) begin
               tens = 4'd0;
               units = 4'd0;
            end else if ($urandom_range(0, 5) == 0) begin
               tens = 4'd0;
            end
            queue_temperature(neg, tens, units);
         end else if (pick < 19) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_segment(OP_SEGTEST, 6'($urandom_range(SEG_COUNT + 1, 63)));
            end else begin
               queue_segment(OP_SEGTEST, 6'($urandom_range(0, SEG_COUNT)));
            end
         end else begin
            queue_segment($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                          6'($urandom));
         end
         counted = counted + 1;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request is taken and every predicted byte popped,
      // then wait out the settle period so that any stray output would show.
      while (request_backlog.size() != 0 || frame_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/sdfb_pkg.sv
src/sdfb_front.sv
src/sdfb_queue.sv
src/sdfb_back.sv
src/segment_display_frame_builder.sv
bench/tb_segment_display_frame_builder.sv
